>>> hdl/lrpf_pkg.sv
// Package for the LRU reuse-distance profiler: sizes, request kinds,
// the command struct broadcast along the cell row, and saturating helpers.
// No dependencies.
package lrpf_pkg;

  localparam int STACK_DEPTH = 64;
  localparam int USER_COUNT  = 2;

  localparam int IDX_W  = $clog2(STACK_DEPTH);
  localparam int FILL_W = $clog2(STACK_DEPTH + 1);
  localparam int USER_W = 1;
  localparam int BLK_W  = 32;
  localparam int BIN_W  = 7;
  localparam int DIST_W = 6;
  localparam int CNT_W  = 32;
  localparam int KIND_W = 2;

  localparam logic [KIND_W-1:0] KIND_ACCESS = 2'd0;
  localparam logic [KIND_W-1:0] KIND_BIN    = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CUM    = 2'd2;

  localparam logic [CNT_W-1:0] SAT_MAX = '1;

  // Broadcast to every cell of the row.
  typedef struct packed {
    logic              cmp_en;
    logic [USER_W-1:0] cmp_user;
    logic [BLK_W-1:0]  cmp_blk;
    logic [FILL_W-1:0] cmp_fill;
    logic              upd_en;
    logic [USER_W-1:0] user;
    logic [IDX_W-1:0]  sel;
  } cell_cmd_t;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    sat_inc = (v == SAT_MAX) ? v : v + CNT_W'(1);
  endfunction

  function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] a,
                                               input logic [CNT_W-1:0] b);
    logic [CNT_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    sat_add = s[CNT_W] ? SAT_MAX : s[CNT_W-1:0];
  endfunction

endpackage

>>> hdl/lrpf_cell.sv
// One position of the recency stacks: a stack entry and a histogram bin for
// every user, the registered match flag and the shift towards the LRU end.
// Depends on lrpf_pkg.
module lrpf_cell (
  input  logic                           clk,
  input  logic                           rst,
  input  lrpf_pkg::cell_cmd_t            cmd,
  input  logic [lrpf_pkg::IDX_W-1:0]     cell_index,
  input  logic [lrpf_pkg::BLK_W-1:0]     prev_entry,
  input  logic                           found_in,
  output logic [lrpf_pkg::BLK_W-1:0]     entry_out,
  output logic                           found_out,
  output logic                           first_hit,
  output logic [lrpf_pkg::CNT_W-1:0]     bin_sel
);

  logic [lrpf_pkg::BLK_W-1:0] entry [lrpf_pkg::USER_COUNT];
  logic [lrpf_pkg::CNT_W-1:0] bin   [lrpf_pkg::USER_COUNT];
  logic                       match;

  // Only positions below the fill take part in the search.
  always_ff @(posedge clk) begin
    if (rst) begin
      match <= 1'b0;
    end else if (cmd.cmp_en) begin
      match <= (lrpf_pkg::FILL_W'(cell_index) < cmd.cmp_fill) &&
               (entry[cmd.cmp_user] == cmd.cmp_blk);
    end
  end

  // Every position up to and including the first hit takes its neighbour's
  // entry; on a miss the whole stack moves and the LRU entry falls off the end.
  always_ff @(posedge clk) begin
    if (cmd.upd_en && !found_in) begin
      entry[cmd.user] <= prev_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int u = 0; u < lrpf_pkg::USER_COUNT; u++) begin
        bin[u] <= '0;
      end
    end else if (cmd.upd_en && first_hit) begin
      bin[cmd.user] <= lrpf_pkg::sat_inc(bin[cmd.user]);
    end
  end

  assign first_hit = match & ~found_in;
  assign found_out = found_in | match;
  assign entry_out = entry[cmd.user];
  assign bin_sel   = (cmd.sel == cell_index) ? bin[cmd.user] : '0;

endmodule

>>> hdl/lru_reuse_distance_profiler_core.sv
// Top level of the LRU reuse-distance profiler: stream handshakes, control
// sequencer, per-user counters and fills, and the row of lrpf_cell.
// Depends on lrpf_pkg and lrpf_cell.
//
//  channel  direction  tdata fields (low bit up)                     tuser
//  s_*      in         user_id, block_number, bin_index (40 bits)    kind
//  m_*      out        was_hit, reuse_distance, bin_value,           -
//                      hits_so_far, misses_so_far, accesses_so_far
//
// An access registers the match of every cell in its transfer cycle; the
// update step then shifts the row and updates the bin and counters.
// A bin read takes the selected bin from the cell read bus; a cumulative read
// adds one bin per cycle through the bus, up to the bound (at most STACK_DEPTH).
// Reset is synchronous and clears histogram bins, counters and fills at once.
// Input is ready only while idle; a finishing step waits while the output
// register still holds an untaken result.
module lru_reuse_distance_profiler_core (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [39:0]  s_tdata,   // user_id, block_number, bin_index
  input  logic [1:0]   s_tuser,   // kind
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [135:0] m_tdata    // was_hit, reuse_distance, bin_value, hits_so_far,
                                  // misses_so_far, accesses_so_far, zero pad
);

  localparam int DEPTH = lrpf_pkg::STACK_DEPTH;
  localparam int UC    = lrpf_pkg::USER_COUNT;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_UPD  = 3'd1;
  localparam logic [2:0] ST_RD   = 3'd2;
  localparam logic [2:0] ST_SUM  = 3'd3;
  localparam logic [2:0] ST_NUL  = 3'd4;

  logic [2:0] state;

  logic [lrpf_pkg::USER_W-1:0] s_user;
  logic [lrpf_pkg::BLK_W-1:0]  s_blk;
  logic [lrpf_pkg::BIN_W-1:0]  s_idx;
  logic                        s_fire;
  logic                        user_ok;

  logic [lrpf_pkg::USER_W-1:0] user_q;
  logic [lrpf_pkg::BLK_W-1:0]  blk_q;
  logic [lrpf_pkg::BIN_W-1:0]  idx_q;
  logic [lrpf_pkg::FILL_W-1:0] sum_idx;
  logic [lrpf_pkg::FILL_W-1:0] sum_lim;
  logic [lrpf_pkg::CNT_W-1:0]  sum;

  logic [lrpf_pkg::FILL_W-1:0] fill    [UC];
  logic [lrpf_pkg::CNT_W-1:0]  hit_cnt [UC];
  logic [lrpf_pkg::CNT_W-1:0]  miss_cnt[UC];
  logic [lrpf_pkg::CNT_W-1:0]  acc_cnt [UC];

  lrpf_pkg::cell_cmd_t        cmd;
  logic [lrpf_pkg::BLK_W-1:0] entry_out[DEPTH];
  logic [lrpf_pkg::CNT_W-1:0] bin_sel  [DEPTH];
  logic [DEPTH-1:0]           found;
  logic [DEPTH-1:0]           first_vec;

  logic [lrpf_pkg::IDX_W-1:0] pos;
  logic [lrpf_pkg::CNT_W-1:0] bus;
  logic                       hit;
  logic                       out_free;
  logic                       load;

  logic [lrpf_pkg::CNT_W-1:0]  h_cur, m_cur, a_cur;
  logic [lrpf_pkg::CNT_W-1:0]  h_new, m_new, a_new;
  logic                        r_hit;
  logic [lrpf_pkg::DIST_W-1:0] r_dist;
  logic [lrpf_pkg::CNT_W-1:0]  r_val, r_hits, r_miss, r_acc;

  logic                        o_hit;
  logic [lrpf_pkg::DIST_W-1:0] o_dist;
  logic [lrpf_pkg::CNT_W-1:0]  o_val, o_hits, o_miss, o_acc;

  assign s_user  = s_tdata[0];
  assign s_blk   = s_tdata[32:1];
  assign s_idx   = s_tdata[39:33];
  assign s_tready = (state == ST_IDLE);
  assign s_fire  = s_tvalid && s_tready;
  assign user_ok = (32'(s_user) < UC);
  assign out_free = !m_tvalid || m_tready;

  always_comb begin
    cmd.cmp_en   = s_fire && (s_tuser == lrpf_pkg::KIND_ACCESS) && user_ok;
    cmd.cmp_user = s_user;
    cmd.cmp_blk  = s_blk;
    cmd.cmp_fill = fill[s_user];
    cmd.upd_en   = (state == ST_UPD) && out_free;
    cmd.user     = user_q;
    cmd.sel      = (state == ST_SUM) ? sum_idx[lrpf_pkg::IDX_W-1:0]
                                     : idx_q[lrpf_pkg::IDX_W-1:0];
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    lrpf_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .cmd        (cmd),
      .cell_index (lrpf_pkg::IDX_W'(i)),
      .prev_entry ((i == 0) ? blk_q : entry_out[(i == 0) ? 0 : i - 1]),
      .found_in   ((i == 0) ? 1'b0 : found[(i == 0) ? 0 : i - 1]),
      .entry_out  (entry_out[i]),
      .found_out  (found[i]),
      .first_hit  (first_vec[i]),
      .bin_sel    (bin_sel[i])
    );
  end

  // At most one cell marks the first hit and one cell drives the read bus.
  always_comb begin
    pos = '0;
    bus = '0;
    for (int i = 0; i < DEPTH; i++) begin
      pos = pos | (first_vec[i] ? lrpf_pkg::IDX_W'(i) : '0);
      bus = bus | bin_sel[i];
    end
  end

  assign hit = found[DEPTH-1];

  always_comb begin
    h_cur = hit_cnt[user_q];
    m_cur = miss_cnt[user_q];
    a_cur = acc_cnt[user_q];
    h_new = hit ? lrpf_pkg::sat_inc(h_cur) : h_cur;
    m_new = hit ? m_cur : lrpf_pkg::sat_inc(m_cur);
    a_new = lrpf_pkg::sat_inc(a_cur);

    load   = 1'b0;
    r_hit  = 1'b0;
    r_dist = '0;
    r_val  = '0;
    r_hits = h_cur;
    r_miss = m_cur;
    r_acc  = a_cur;
    case (state)
      ST_UPD: begin
        load   = out_free;
        r_hit  = hit;
        r_dist = lrpf_pkg::DIST_W'(pos);
        r_hits = h_new;
        r_miss = m_new;
        r_acc  = a_new;
      end
      ST_RD: begin
        load  = out_free;
        r_val = (32'(idx_q) < DEPTH) ? bus : '0;
      end
      ST_SUM: begin
        load  = out_free && (sum_idx == sum_lim);
        r_val = sum;
      end
      ST_NUL: begin
        load   = out_free;
        r_hits = '0;
        r_miss = '0;
        r_acc  = '0;
      end
      default: begin
        load = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      case (state)
        ST_IDLE: begin
          if (s_fire) begin
            if (!user_ok) begin
              state <= ST_NUL;
            end else begin
              case (s_tuser)
                lrpf_pkg::KIND_ACCESS: state <= ST_UPD;
                lrpf_pkg::KIND_BIN:    state <= ST_RD;
                lrpf_pkg::KIND_CUM:    state <= ST_SUM;
                default:               state <= ST_NUL;
              endcase
            end
          end
        end
        ST_UPD, ST_RD, ST_SUM, ST_NUL: begin
          if (load) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (s_fire) begin
      user_q  <= s_user;
      blk_q   <= s_blk;
      idx_q   <= s_idx;
      sum     <= '0;
      sum_idx <= '0;
      sum_lim <= (32'(s_idx) > DEPTH) ? lrpf_pkg::FILL_W'(DEPTH)
                                      : lrpf_pkg::FILL_W'(s_idx);
    end else if (state == ST_SUM && sum_idx != sum_lim) begin
      sum     <= lrpf_pkg::sat_add(sum, bus);
      sum_idx <= sum_idx + lrpf_pkg::FILL_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int u = 0; u < UC; u++) begin
        fill[u]     <= '0;
        hit_cnt[u]  <= '0;
        miss_cnt[u] <= '0;
        acc_cnt[u]  <= '0;
      end
    end else if (cmd.upd_en) begin
      hit_cnt[user_q]  <= h_new;
      miss_cnt[user_q] <= m_new;
      acc_cnt[user_q]  <= a_new;
      if (!hit && (32'(fill[user_q]) < DEPTH)) begin
        fill[user_q] <= fill[user_q] + lrpf_pkg::FILL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      o_hit  <= r_hit;
      o_dist <= r_dist;
      o_val  <= r_val;
      o_hits <= r_hits;
      o_miss <= r_miss;
      o_acc  <= r_acc;
    end
  end

  assign m_tdata = {1'b0, o_acc, o_miss, o_hits, o_val, o_dist, o_hit};

  // Assertions.
  a_one_first_hit: assert property (@(posedge clk) disable iff (rst)
    (state == ST_UPD) |-> $onehot0(first_vec))
    else $error("more than one cell marks the first hit");

  a_sum_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SUM) |-> (sum_idx <= sum_lim && 32'(sum_lim) <= DEPTH))
    else $error("cumulative read ran past its bound");

  a_hit_counts: assert property (@(posedge clk) disable iff (rst)
    (cmd.upd_en && hit) |=> (m_tvalid && o_hit && state == ST_IDLE))
    else $error("hit result not delivered after the row update");

  for (genvar u = 0; u < UC; u++) begin : g_fill_chk
    a_fill_limit: assert property (@(posedge clk) disable iff (rst)
      32'(fill[u]) <= DEPTH)
      else $error("stack fill exceeds the stack depth");
  end

endmodule

>>> verif/tb_lru_reuse_distance_profiler_core.sv
// Self-checking testbench for lru_reuse_distance_profiler_core: directed and random
// accesses and histogram reads, scored against a behavioural recency-stack predictor.
// Depends on lrpf_pkg and the core RTL.
`timescale 1ns / 100ps

module tb_lru_reuse_distance_profiler_core;

  localparam logic [lrpf_pkg::KIND_W-1:0] KIND_UNUSED = 2'd3;
  localparam int NUM_RANDOM      = 1630;
  localparam int CALM_ITEMS      = 150;
  localparam int STALL_LIMIT     = 3000;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int DRAIN_CYCLES    = 80;

  typedef struct {
    logic                        was_hit;
    logic [lrpf_pkg::DIST_W-1:0] distance;
    logic [lrpf_pkg::CNT_W-1:0]  bin_value;
    logic [lrpf_pkg::CNT_W-1:0]  hits;
    logic [lrpf_pkg::CNT_W-1:0]  misses;
    logic [lrpf_pkg::CNT_W-1:0]  accesses;
  } profile_result_t;

  class reuse_scoreboard;
    logic [lrpf_pkg::BLK_W-1:0] recency [lrpf_pkg::USER_COUNT][lrpf_pkg::STACK_DEPTH];
    int                         depth_used [lrpf_pkg::USER_COUNT];
    logic [lrpf_pkg::CNT_W-1:0] histogram [lrpf_pkg::USER_COUNT][lrpf_pkg::STACK_DEPTH];
    logic [lrpf_pkg::CNT_W-1:0] hit_cnt [lrpf_pkg::USER_COUNT];
    logic [lrpf_pkg::CNT_W-1:0] miss_cnt [lrpf_pkg::USER_COUNT];
    logic [lrpf_pkg::CNT_W-1:0] access_cnt [lrpf_pkg::USER_COUNT];
    profile_result_t            pending_results [$];
    int                         mismatch_count;

    function new();
      for (int u = 0; u < lrpf_pkg::USER_COUNT; u++) begin
        depth_used[u] = 0;
        hit_cnt[u]    = '0;
        miss_cnt[u]   = '0;
        access_cnt[u] = '0;
        for (int i = 0; i < lrpf_pkg::STACK_DEPTH; i++) begin
          recency[u][i]   = '0;
          histogram[u][i] = '0;
        end
      end
      mismatch_count = 0;
    endfunction

    function logic [lrpf_pkg::CNT_W-1:0] bump(logic [lrpf_pkg::CNT_W-1:0] v);
      return (v == '1) ? v : v + 1'b1;
    endfunction

    function int outstanding();
      return pending_results.size();
    endfunction

    // Works out the result of one accepted request and updates the predicted state.
    function void note_request(logic [lrpf_pkg::KIND_W-1:0] kind,
                               logic [lrpf_pkg::USER_W-1:0] user,
                               logic [lrpf_pkg::BLK_W-1:0] blk,
                               logic [lrpf_pkg::BIN_W-1:0] idx);
      profile_result_t           r;
      int                        u;
      int                        pos;
      int                        top;
      int                        lim;
      logic [lrpf_pkg::CNT_W:0]  sum;
      r = '{default: '0};
      u = int'(user);
      if (kind != KIND_UNUSED && u < lrpf_pkg::USER_COUNT) begin
        if (kind == lrpf_pkg::KIND_ACCESS) begin
          pos = depth_used[u];
          for (int i = depth_used[u] - 1; i >= 0; i--)
            if (recency[u][i] == blk) pos = i;
          if (pos < depth_used[u]) begin
            r.was_hit = 1'b1;
            r.distance = lrpf_pkg::DIST_W'(pos);
            histogram[u][pos] = bump(histogram[u][pos]);
            hit_cnt[u] = bump(hit_cnt[u]);
            for (int i = pos; i > 0; i--) recency[u][i] = recency[u][i-1];
            recency[u][0] = blk;
          end else begin
            top = (depth_used[u] == lrpf_pkg::STACK_DEPTH) ? lrpf_pkg::STACK_DEPTH - 1
                                                           : depth_used[u];
            miss_cnt[u] = bump(miss_cnt[u]);
            for (int i = top; i > 0; i--) recency[u][i] = recency[u][i-1];
            recency[u][0] = blk;
            if (depth_used[u] < lrpf_pkg::STACK_DEPTH) depth_used[u]++;
          end
          access_cnt[u] = bump(access_cnt[u]);
        end else if (kind == lrpf_pkg::KIND_BIN) begin
          if (int'(idx) < lrpf_pkg::STACK_DEPTH)
            r.bin_value = histogram[u][idx[lrpf_pkg::IDX_W-1:0]];
        end else begin
          lim = (int'(idx) > lrpf_pkg::STACK_DEPTH) ? lrpf_pkg::STACK_DEPTH : int'(idx);
          sum = '0;
          for (int i = 0; i < lim; i++) begin
            sum = {1'b0, sum[lrpf_pkg::CNT_W-1:0]} + {1'b0, histogram[u][i]};
            if (sum[lrpf_pkg::CNT_W]) sum = {1'b0, {lrpf_pkg::CNT_W{1'b1}}};
          end
          r.bin_value = sum[lrpf_pkg::CNT_W-1:0];
        end
        r.hits     = hit_cnt[u];
        r.misses   = miss_cnt[u];
        r.accesses = access_cnt[u];
      end
      pending_results.push_back(r);
    endfunction

    function void compare_field(string name, logic [lrpf_pkg::CNT_W-1:0] want,
                                logic [lrpf_pkg::CNT_W-1:0] got);
      if (got !== want) begin
        mismatch_count++;
        if (mismatch_count <= 60)
          $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      end
    endfunction

    function void check_result(logic [135:0] data);
      profile_result_t want;
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 60)
          $display("%0t: unexpected result, expected none, actual %h", $time, data);
        return;
      end
      want = pending_results.pop_front();
      compare_field("was_hit", lrpf_pkg::CNT_W'(want.was_hit), lrpf_pkg::CNT_W'(data[0]));
      compare_field("reuse_distance", lrpf_pkg::CNT_W'(want.distance),
                    lrpf_pkg::CNT_W'(data[6:1]));
      compare_field("bin_value", want.bin_value, data[38:7]);
      compare_field("hits_so_far", want.hits, data[70:39]);
      compare_field("misses_so_far", want.misses, data[102:71]);
      compare_field("accesses_so_far", want.accesses, data[134:103]);
      compare_field("pad", '0, lrpf_pkg::CNT_W'(data[135]));
    endfunction
  endclass

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [39:0]  s_tdata = '0;
  logic [1:0]   s_tuser = '0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [135:0] m_tdata;

  reuse_scoreboard            sb;
  bit                         calm = 1'b0;
  bit                         hold_req = 1'b0;
  int                         stall_cycles = 0;
  logic [lrpf_pkg::BLK_W-1:0] block_pool [100];

  lru_reuse_distance_profiler_core dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Offers one request and returns just after the edge of its transfer.
  task automatic send_request(logic [lrpf_pkg::KIND_W-1:0] kind,
                              logic [lrpf_pkg::USER_W-1:0] user,
                              logic [lrpf_pkg::BLK_W-1:0] blk,
                              logic [lrpf_pkg::BIN_W-1:0] idx);
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= {idx, blk, user};
    do @(posedge clk); while (!s_tready);
    sb.note_request(kind, user, blk, idx);
  endtask

  task automatic sender_gap();
    if (!calm && $urandom_range(0, 5) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
  endtask

  // Receiver: random back-pressure, plus one long hold-off when asked for.
  initial begin
    int rx_gap;
    int hold_cnt;
    rx_gap = 0;
    hold_cnt = 0;
    forever begin
      @(posedge clk);
      if (!rst && m_tvalid && m_tready) sb.check_result(m_tdata);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_cnt = HOLD_OFF_CYCLES;
      end
      if (rst) begin
        m_tready <= 1'b0;
      end else if (hold_cnt > 0) begin
        hold_cnt--;
        m_tready <= 1'b0;
      end else if (rx_gap > 0) begin
        rx_gap--;
        m_tready <= 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        rx_gap = $urandom_range(1, 14) - 1;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles + 1 >= STALL_LIMIT) begin
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  initial begin
    int                          locality;
    int                          r;
    logic [lrpf_pkg::KIND_W-1:0] kind;
    logic [lrpf_pkg::USER_W-1:0] user;
    logic [lrpf_pkg::BLK_W-1:0]  blk;
    logic [lrpf_pkg::BIN_W-1:0]  idx;
    sb = new();
    locality = 15;
    for (int i = 0; i < 100; i++) block_pool[i] = $urandom;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: hits at shallow depths, extreme block numbers and the edge read bounds.
    send_request(lrpf_pkg::KIND_ACCESS, 1'b0, 32'h0000_0000, 7'd0);
    send_request(lrpf_pkg::KIND_ACCESS, 1'b0, 32'h0000_0000, 7'd127);
    send_request(lrpf_pkg::KIND_ACCESS, 1'b0, 32'hFFFF_FFFF, 7'd0);
    send_request(lrpf_pkg::KIND_ACCESS, 1'b0, 32'h0000_0000, 7'd64);
    send_request(lrpf_pkg::KIND_ACCESS, 1'b0, 32'hFFFF_FFFF, 7'd0);
    send_request(lrpf_pkg::KIND_ACCESS, 1'b1, 32'hA5A5_A5A5, 7'd0);
    send_request(lrpf_pkg::KIND_ACCESS, 1'b1, 32'hA5A5_A5A5, 7'd0);
    send_request(lrpf_pkg::KIND_BIN, 1'b0, $urandom, 7'd0);
    send_request(lrpf_pkg::KIND_BIN, 1'b0, $urandom, 7'd1);
    send_request(lrpf_pkg::KIND_BIN, 1'b0, $urandom, 7'd63);
    send_request(lrpf_pkg::KIND_BIN, 1'b0, $urandom, 7'd64);
    send_request(lrpf_pkg::KIND_BIN, 1'b0, $urandom, 7'd127);
    send_request(lrpf_pkg::KIND_CUM, 1'b0, $urandom, 7'd0);
    send_request(lrpf_pkg::KIND_CUM, 1'b0, $urandom, 7'd1);
    send_request(lrpf_pkg::KIND_CUM, 1'b0, $urandom, 7'd2);
    send_request(lrpf_pkg::KIND_CUM, 1'b0, $urandom, 7'd64);
    send_request(lrpf_pkg::KIND_CUM, 1'b0, $urandom, 7'd65);
    send_request(lrpf_pkg::KIND_CUM, 1'b0, $urandom, 7'd127);
    send_request(lrpf_pkg::KIND_BIN, 1'b1, $urandom, 7'd0);
    send_request(lrpf_pkg::KIND_CUM, 1'b1, $urandom, 7'd127);
    send_request(KIND_UNUSED, 1'b0, 32'hFFFF_FFFF, 7'd127);
    send_request(KIND_UNUSED, 1'b1, 32'h0000_0000, 7'd0);

    // Random: mostly accesses drawn from a pool, so that stacks fill and hit deep.
    for (int n = 0; n < NUM_RANDOM; n++) begin
      calm = (n >= NUM_RANDOM - CALM_ITEMS);
      if (n % 100 == 0) begin
        r = $urandom_range(0, 5);
        locality = (r == 0) ? 3 : (r == 1) ? 15 : (r == 2) ? 40 :
                   (r == 3) ? 63 : (r == 4) ? 70 : 99;
      end
      if (n == 300) hold_req = 1'b1;
      if (n == 700) begin
        s_tvalid <= 1'b0;
        do @(posedge clk); while (sb.outstanding() != 0);
      end
      r = $urandom_range(0, 99);
      kind = (r < 72) ? lrpf_pkg::KIND_ACCESS : (r < 84) ? lrpf_pkg::KIND_BIN :
             (r < 95) ? lrpf_pkg::KIND_CUM : KIND_UNUSED;
      user = lrpf_pkg::USER_W'($urandom_range(0, 1));
      blk = ($urandom_range(0, 4) == 0) ? $urandom : block_pool[$urandom_range(0, locality)];
      idx = ($urandom_range(0, 1) == 0) ? lrpf_pkg::BIN_W'($urandom_range(0, 127))
                                        : lrpf_pkg::BIN_W'($urandom_range(0,
                                                             lrpf_pkg::STACK_DEPTH));
      send_request(kind, user, blk, idx);
      sender_gap();
    end
    s_tvalid <= 1'b0;

    while (sb.outstanding() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.mismatch_count == 0 && sb.outstanding() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
